### rtl/cbc_pkg.sv
// cbc_pkg: shared types, codes and helpers for the cartridge bank controller
// no dependencies; used by cbc_xlate and cartridge_bank_controller_top
package cbc_pkg;

  // result codes of one bus request
  typedef enum logic [2:0] {
    ACC_NONE   = 3'd0,
    ACC_ROM    = 3'd1,
    ACC_RAM_RD = 3'd2,
    ACC_RAM_WR = 3'd3,
    ACC_CLK_RD = 3'd4,
    ACC_REG    = 3'd5
  } acc_t;

  // cartridge types
  localparam logic [2:0] CART_ROM  = 3'd0;
  localparam logic [2:0] CART_MBC1 = 3'd1;
  localparam logic [2:0] CART_MBC2 = 3'd2;
  localparam logic [2:0] CART_MBC3 = 3'd3;
  localparam logic [2:0] CART_MBC5 = 3'd4;

  // bus operation
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // ram size header codes
  localparam logic [2:0] RAM_NONE  = 3'd0;
  localparam logic [2:0] RAM_2K    = 3'd1;
  localparam logic [2:0] RAM_8K    = 3'd2;
  localparam logic [2:0] RAM_32K   = 3'd3;
  localparam logic [2:0] RAM_128K  = 3'd4;
  localparam logic [2:0] RAM_64K   = 3'd5;

  // clock register select codes
  localparam logic [7:0] CLK_SEC      = 8'h08;
  localparam logic [7:0] CLK_MIN      = 8'h09;
  localparam logic [7:0] CLK_HOUR     = 8'h0A;
  localparam logic [7:0] CLK_DAY_LOW  = 8'h0B;
  localparam logic [7:0] CLK_DAY_HIGH = 8'h0C;
  localparam logic [7:0] CLK_NONE     = 8'hFF;
  localparam logic [7:0] RAM_BANK_MAX = 8'h07;

  // configuration register indexes
  localparam logic [1:0] CFG_CART_TYPE = 2'd0;
  localparam logic [1:0] CFG_ROM_SIZE  = 2'd1;
  localparam logic [1:0] CFG_RAM_SIZE  = 2'd2;

  localparam logic [9:0] MAX_ROM_BANKS = 10'd512;
  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

  typedef struct packed {
    logic [2:0] cart_type;
    logic [9:0] rom_size_banks;
    logic [2:0] ram_size_code;
  } cbc_cfg_t;

  typedef struct packed {
    logic [7:0] rom_bank_low;
    logic       rom_bank_high;
    logic [3:0] ram_bank;
    logic       ram_enable;
    logic       banking_mode;
    logic [7:0] clock_select;
    logic       latch_armed;
    logic [5:0] clock_seconds;
    logic [5:0] clock_minutes;
    logic [4:0] clock_hours;
    logic [7:0] clock_day_low;
    logic [7:0] clock_day_high;
  } cbc_state_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] address;
    logic [7:0]  write_data;
  } cbc_req_t;

  typedef struct packed {
    acc_t        access;
    logic [22:0] phys_addr;
    logic [7:0]  data;
    logic        force_high_nibble;
  } cbc_res_t;

  localparam cbc_state_t STATE_RESET = '{
    rom_bank_low:   8'd1,
    rom_bank_high:  1'b0,
    ram_bank:       4'd0,
    ram_enable:     1'b0,
    banking_mode:   1'b0,
    clock_select:   CLK_NONE,
    latch_armed:    1'b0,
    clock_seconds:  6'd0,
    clock_minutes:  6'd0,
    clock_hours:    5'd0,
    clock_day_low:  8'd0,
    clock_day_high: 8'd0
  };

  // ram size in bytes for a header code
  function automatic logic [17:0] ram_limit(input logic [2:0] code);
    logic [17:0] lim;
    case (code)
      RAM_2K:   lim = 18'h00800;
      RAM_8K:   lim = 18'h02000;
      RAM_32K:  lim = 18'h08000;
      RAM_128K: lim = 18'h20000;
      RAM_64K:  lim = 18'h10000;
      default:  lim = 18'h00000;
    endcase
    return lim;
  endfunction

endpackage

### rtl/cbc_xlate.sv
// cbc_xlate: decode of one bus request into a result and the next bank state
// depends on cbc_pkg
module cbc_xlate (
  input  cbc_pkg::cbc_cfg_t   cfg,
  input  cbc_pkg::cbc_state_t st,
  input  cbc_pkg::cbc_req_t   req,
  output cbc_pkg::cbc_state_t st_nxt,
  output cbc_pkg::cbc_res_t   res
);

  logic        wr;
  logic [15:0] a;
  logic [7:0]  v;
  logic [8:0]  rom_bank;
  logic [9:0]  rom_lim;
  logic [3:0]  ram_bank_sel;
  logic [16:0] ram_phys;
  logic        clk_mapped;
  logic        known_type;

  assign wr = (req.operation == cbc_pkg::OP_WRITE);
  assign a  = req.address;
  assign v  = req.write_data;

  assign known_type = (cfg.cart_type != cbc_pkg::CART_ROM) &&
                      (cfg.cart_type <= cbc_pkg::CART_MBC5);
  assign clk_mapped = (cfg.cart_type == cbc_pkg::CART_MBC3) && st.ram_enable &&
                      (st.clock_select >= cbc_pkg::CLK_SEC) &&
                      (st.clock_select <= cbc_pkg::CLK_DAY_HIGH);
  assign rom_lim = (cfg.rom_size_banks > cbc_pkg::MAX_ROM_BANKS) ?
                   cbc_pkg::MAX_ROM_BANKS : cfg.rom_size_banks;

  // rom bank for the addressed window
  always_comb begin
    rom_bank = 9'd1;
    if (!a[14]) begin
      rom_bank = (cfg.cart_type == cbc_pkg::CART_MBC1 && st.banking_mode) ?
                 {2'b00, st.ram_bank[1:0], 5'd0} : 9'd0;
    end else begin
      case (cfg.cart_type)
        cbc_pkg::CART_MBC1: begin
          rom_bank = {2'b00, st.ram_bank[1:0], st.rom_bank_low[4:1],
                      st.rom_bank_low[0] | (st.rom_bank_low[4:0] == 5'd0)};
        end
        cbc_pkg::CART_MBC2: begin
          rom_bank = {5'd0, st.rom_bank_low[3:1],
                      st.rom_bank_low[0] | (st.rom_bank_low[3:0] == 4'd0)};
        end
        cbc_pkg::CART_MBC3: begin
          rom_bank = {2'b00, st.rom_bank_low[6:1],
                      st.rom_bank_low[0] | (st.rom_bank_low[6:0] == 7'd0)};
        end
        cbc_pkg::CART_MBC5: begin
          rom_bank = {st.rom_bank_high, st.rom_bank_low};
        end
        default: rom_bank = 9'd1;
      endcase
    end
  end

  // external ram bank and byte address
  always_comb begin
    ram_bank_sel = st.ram_bank;
    if (cfg.cart_type == cbc_pkg::CART_MBC1) begin
      ram_bank_sel = st.banking_mode ? {2'b00, st.ram_bank[1:0]} : 4'd0;
    end
  end
  assign ram_phys = {ram_bank_sel, a[12:0]};

  always_comb begin
    st_nxt = st;
    res.access = cbc_pkg::ACC_NONE;
    res.phys_addr = 23'd0;
    res.data = 8'd0;
    res.force_high_nibble = 1'b0;
    if (!a[15]) begin
      if (wr) begin
        // mapper register writes
        res.access = cbc_pkg::ACC_REG;
        case (cfg.cart_type)
          cbc_pkg::CART_MBC1: begin
            case (a[14:13])
              2'd0: st_nxt.ram_enable = (v[3:0] == cbc_pkg::RAM_ENABLE_KEY);
              2'd1: st_nxt.rom_bank_low = {3'd0, v[4:1], v[0] | (v[4:0] == 5'd0)};
              2'd2: st_nxt.ram_bank = {2'b00, v[1:0]};
              default: st_nxt.banking_mode = v[0];
            endcase
          end
          cbc_pkg::CART_MBC2: begin
            if (a[14]) begin
              res.access = cbc_pkg::ACC_NONE;
            end else if (a[8]) begin
              st_nxt.rom_bank_low = {4'd0, v[3:1], v[0] | (v[3:0] == 4'd0)};
            end else begin
              st_nxt.ram_enable = (v[3:0] == cbc_pkg::RAM_ENABLE_KEY);
            end
          end
          cbc_pkg::CART_MBC3: begin
            case (a[14:13])
              2'd0: st_nxt.ram_enable = (v[3:0] == cbc_pkg::RAM_ENABLE_KEY);
              2'd1: st_nxt.rom_bank_low = {1'b0, v[6:1], v[0] | (v[6:0] == 7'd0)};
              2'd2: begin
                if (v <= cbc_pkg::RAM_BANK_MAX) begin
                  st_nxt.ram_bank = v[3:0];
                  st_nxt.clock_select = cbc_pkg::CLK_NONE;
                end else if (v <= cbc_pkg::CLK_DAY_HIGH) begin
                  st_nxt.clock_select = v;
                end
              end
              default: begin
                // latch sequence only arms and disarms
                if (v == 8'd0) begin
                  st_nxt.latch_armed = 1'b1;
                end else if (v == 8'd1) begin
                  st_nxt.latch_armed = 1'b0;
                end
              end
            endcase
          end
          cbc_pkg::CART_MBC5: begin
            case (a[14:13])
              2'd0: st_nxt.ram_enable = (v[3:0] == cbc_pkg::RAM_ENABLE_KEY);
              2'd1: begin
                if (a[12]) begin
                  st_nxt.rom_bank_high = v[0];
                end else begin
                  st_nxt.rom_bank_low = v;
                end
              end
              2'd2: st_nxt.ram_bank = v[3:0];
              default: res.access = cbc_pkg::ACC_NONE;
            endcase
          end
          default: res.access = cbc_pkg::ACC_NONE;
        endcase
      end else if ({1'b0, rom_bank} < rom_lim) begin
        res.access = cbc_pkg::ACC_ROM;
        res.phys_addr = {rom_bank, a[13:0]};
      end
    end else if (a[15:13] == 3'b101) begin
      if (clk_mapped) begin
        if (wr) begin
          res.access = cbc_pkg::ACC_REG;
          case (st.clock_select)
            cbc_pkg::CLK_SEC: begin
              st_nxt.clock_seconds = v[5:0];
              res.data = {2'b00, v[5:0]};
            end
            cbc_pkg::CLK_MIN: begin
              st_nxt.clock_minutes = v[5:0];
              res.data = {2'b00, v[5:0]};
            end
            cbc_pkg::CLK_HOUR: begin
              st_nxt.clock_hours = v[4:0];
              res.data = {3'b000, v[4:0]};
            end
            cbc_pkg::CLK_DAY_LOW: begin
              st_nxt.clock_day_low = v;
              res.data = v;
            end
            default: begin
              st_nxt.clock_day_high = v & 8'hC1;
              res.data = v & 8'hC1;
            end
          endcase
        end else begin
          res.access = cbc_pkg::ACC_CLK_RD;
          case (st.clock_select)
            cbc_pkg::CLK_SEC:     res.data = {2'b00, st.clock_seconds};
            cbc_pkg::CLK_MIN:     res.data = {2'b00, st.clock_minutes};
            cbc_pkg::CLK_HOUR:    res.data = {3'b000, st.clock_hours};
            cbc_pkg::CLK_DAY_LOW: res.data = st.clock_day_low;
            default:              res.data = st.clock_day_high;
          endcase
        end
      end else if (st.ram_enable && cfg.cart_type == cbc_pkg::CART_MBC2) begin
        // 512 nibble ram, high nibble reads back as ones
        res.phys_addr = {14'd0, a[8:0]};
        if (wr) begin
          res.access = cbc_pkg::ACC_RAM_WR;
          res.data = {4'd0, v[3:0]};
        end else begin
          res.access = cbc_pkg::ACC_RAM_RD;
          res.force_high_nibble = 1'b1;
        end
      end else if (st.ram_enable && known_type &&
                   ({1'b0, ram_phys} < cbc_pkg::ram_limit(cfg.ram_size_code))) begin
        res.phys_addr = {6'd0, ram_phys};
        if (wr) begin
          res.access = cbc_pkg::ACC_RAM_WR;
          res.data = v;
        end else begin
          res.access = cbc_pkg::ACC_RAM_RD;
        end
      end
    end
  end

endmodule

### rtl/cartridge_bank_controller_top.sv
// cartridge_bank_controller_top: bus request register, decode and result register
// depends on cbc_pkg and cbc_xlate
//
// usage
// - in_* channel: one cpu bus request per accept (valid and ready both high),
//   operation 0 read / 1 write, 16 bit address, write byte
// - out_* channel: exactly one result per request, in request order:
//   access code, physical rom/ram byte address, data byte, nibble force flag
// - cfg_*: write enable, register index (0 cart type, 1 rom banks, 2 ram size
//   code) and data; write only while no request is in flight (not enforced)
// - a request moves from the request register to the result register when
//   that is free (two register stages: request register, result register)
// - throughput: one request per cycle while out_ready is high; the mapper
//   registers are updated in the same cycle the result is registered, so the
//   next request already sees them
// - when out_ready is low the result register holds, the request register
//   still takes one more request, then in_ready drops
// - reset (rst_n low, synchronous): both stages empty, rom bank 1, clock
//   select none, all other mapper state cleared, rom only type, 2 rom banks,
//   no ram
module cartridge_bank_controller_top (
  input  logic        clk,
  input  logic        rst_n,
  // bus request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_access,
  output logic [22:0] out_phys_addr,
  output logic [7:0]  out_data,
  output logic        out_force_high_nibble,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  cbc_pkg::cbc_cfg_t   cfg_r;
  cbc_pkg::cbc_state_t st_r;
  cbc_pkg::cbc_state_t st_nxt;
  cbc_pkg::cbc_req_t   req_r;
  cbc_pkg::cbc_res_t   res_nxt;
  cbc_pkg::cbc_res_t   res_r;
  logic                req_valid_r;
  logic                out_valid_r;
  logic                advance;

  // request moves to the result register when that register is free or drained
  assign advance  = req_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !req_valid_r || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cart_type      <= cbc_pkg::CART_ROM;
      cfg_r.rom_size_banks <= 10'd2;
      cfg_r.ram_size_code  <= cbc_pkg::RAM_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        cbc_pkg::CFG_CART_TYPE: cfg_r.cart_type      <= cfg_data[2:0];
        cbc_pkg::CFG_ROM_SIZE:  cfg_r.rom_size_banks <= cfg_data;
        cbc_pkg::CFG_RAM_SIZE:  cfg_r.ram_size_code  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r.operation  <= in_operation;
      req_r.address    <= in_address;
      req_r.write_data <= in_write_data;
    end
  end

  cbc_xlate u_xlate (
    .cfg    (cfg_r),
    .st     (st_r),
    .req    (req_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // mapper state commits together with the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= cbc_pkg::STATE_RESET;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_access            = res_r.access;
  assign out_phys_addr         = res_r.phys_addr;
  assign out_data              = res_r.data;
  assign out_force_high_nibble = res_r.force_high_nibble;

endmodule
